/* rtl/aarm_pkg.sv */
// aarm_pkg.sv: shared widths, pipeline lengths and rounding helpers
`timescale 1ns / 1ps
package aarm_pkg;
    localparam int AXIS_W = 16;
    localparam int Q30_W  = 33;
    localparam int OUT_W  = 18;
    localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
    localparam logic [34:0] PI_Q32 = 35'd13493037705;

    // cells in each chained unit
    localparam int SQRT_CELLS = 48;   // one root bit per cell, radicand n2 << 32 (< 2^96)
    localparam int DIV_CELLS  = 32;   // quotient bits, 31 needed plus saturation bit
    localparam int POLY_CELLS = 7;    // horner brackets, three stages each
    localparam int SC_LAT     = 1 + 1 + 3 * POLY_CELLS + 1;
    localparam int NORM_LAT   = 1 + SQRT_CELLS + 1 + DIV_CELLS + 1;

    // horner divisors, indexed by k
    function automatic logic [7:0] sin_div(input logic [2:0] k);
        logic [7:0] kk;
        begin
            kk = {5'd0, k};
            return (8'd2 * kk) * (8'd2 * kk + 8'd1);
        end
    endfunction

    function automatic logic [7:0] cos_div(input logic [2:0] k);
        logic [7:0] kk;
        begin
            kk = {5'd0, k};
            return (8'd2 * kk - 8'd1) * (8'd2 * kk);
        end
    endfunction

    // signed q30 product, rounded half away from zero
    function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic [32:0] m;
        begin
            ma = a[32] ? 32'(-a) : a[31:0];
            mb = b[32] ? 32'(-b) : b[31:0];
            p  = ma * mb + 64'd536870912;
            m  = p[62:30];
            return (a[32] ^ b[32]) ? -$signed(m) : $signed(m);
        end
    endfunction

    // q2.30 to saturated q1.16, half away from zero
    function automatic logic [17:0] to_q16(input logic signed [34:0] v);
        logic [34:0] m;
        logic [34:0] r;
        logic [17:0] s;
        begin
            m = v[34] ? 35'(-v) : v;
            r = (m + 35'd8192) >> 14;
            s = (r > 35'd65536) ? 18'd65536 : r[17:0];
            return v[34] ? 18'(-s) : s;
        end
    endfunction
endpackage

/* rtl/axis_angle_rotation_matrix.sv */
// axis_angle_rotation_matrix.sv: top level, axis-angle to rotation matrix pipeline
//
//   channel  | ports                                    | handshake
//   ---------+------------------------------------------+---------------------------
//   command  | i_axis_x/y/z, i_turn_angle               | start high, busy low
//   result   | o_m00..o_m22, o_zero_axis                | o_valid one cycle, no stall
//
// one item per cycle, back to back; o_valid travels down a valid chain as long as the
// pipeline (the square root chain, one cell per root bit, and the divider chain
// set the length; sine and cosine run beside them in the horner cells and wait in a
// delay line); the receiver cannot stall, so nothing ever holds the pipeline
// busy is always low; synchronous active-low reset clears the valid chain only
`timescale 1ns / 1ps
module axis_angle_rotation_matrix import aarm_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [15:0]       i_axis_x,
    input  logic signed [15:0]       i_axis_y,
    input  logic signed [15:0]       i_axis_z,
    input  logic [15:0]              i_turn_angle,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_m00,
    output logic signed [OUT_W-1:0]  o_m01,
    output logic signed [OUT_W-1:0]  o_m02,
    output logic signed [OUT_W-1:0]  o_m10,
    output logic signed [OUT_W-1:0]  o_m11,
    output logic signed [OUT_W-1:0]  o_m12,
    output logic signed [OUT_W-1:0]  o_m20,
    output logic signed [OUT_W-1:0]  o_m21,
    output logic signed [OUT_W-1:0]  o_m22,
    output logic                     o_zero_axis
);
    localparam int TOT = NORM_LAT + 2;
    // side data through the root: signs, magnitudes, zero flag
    localparam int SIDE_W = 3 + 3 * 16 + 1;
    localparam int DSIDE_W = 3 + 1;

    assign busy = 1'b0;

    // valid chain
    logic [TOT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT-2:0], start};
        end
    end
    assign o_valid = r_vld[TOT-1];

    // stage 0: squares, magnitudes, phase
    logic [15:0] n_mx, n_my, n_mz;
    logic [33:0] n_n2;
    logic [23:0] n_ang;
    logic [31:0] n_ph;
    always_comb begin
        n_mx = i_axis_x[15] ? 16'(-i_axis_x) : i_axis_x;
        n_my = i_axis_y[15] ? 16'(-i_axis_y) : i_axis_y;
        n_mz = i_axis_z[15] ? 16'(-i_axis_z) : i_axis_z;
        n_n2 = ({18'd0, n_mx} * {18'd0, n_mx}) + ({18'd0, n_my} * {18'd0, n_my}) +
               ({18'd0, n_mz} * {18'd0, n_mz});
        n_ang = 24'(i_turn_angle);
        n_ph = 32'(n_ang[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    end

    logic [95:0] r_rad;
    logic [SIDE_W-1:0] r_side0;
    logic [29:0] r_p;
    logic [1:0]  r_q0;
    always_ff @(posedge i_clk) begin
        r_rad   <= {30'd0, n_n2, 32'd0};
        r_side0 <= {i_axis_x[15], i_axis_y[15], i_axis_z[15], n_mx, n_my, n_mz,
                    (n_n2 == 34'd0)};
        r_p     <= n_ph[29:0];
        r_q0    <= n_ph[31:30];
    end

    // square root chain
    logic [95:0]       s_rad  [SQRT_CELLS+1];
    logic [48:0]       s_rem  [SQRT_CELLS+1];
    logic [47:0]       s_root [SQRT_CELLS+1];
    logic [SIDE_W-1:0] s_side [SQRT_CELLS+1];
    assign s_rad[0]  = r_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = r_side0;
    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        aarm_sqrt_cell #(.STEP(g), .SIDE_W(SIDE_W)) u_cell (
            .i_clk (i_clk),
            .i_rad (s_rad[g]), .i_rem (s_rem[g]), .i_root(s_root[g]), .i_side(s_side[g]),
            .o_rad (s_rad[g+1]), .o_rem (s_rem[g+1]), .o_root(s_root[g+1]),
            .o_side(s_side[g+1])
        );
    end

    // divider setup: (m << 46) + r/2 over r; 31 high bits are exactly m << 15 plus carry
    // the dividend m*2^46 + r/2 is split as integer part (m*2^46 + r/2) / 2^31 handled by
    // long division over all its bits: feed the low 31 bits through the chain
    logic [47:0] w_r;
    logic [SIDE_W-1:0] w_sd;
    logic [62:0] n_dvd [3];
    assign w_r  = s_root[SQRT_CELLS];
    assign w_sd = s_side[SQRT_CELLS];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_dvd[j] = ({47'd0, w_sd[1 + 16*(2-j) +: 16]} << 46) + 63'(w_r >> 1);
        end
    end
    // first stage: the high part is already below r, so it needs no quotient bits of its own;
    // the quotient starts at zero and the high part is the starting remainder
    logic [48:0]       r_den;
    logic [3*49-1:0]   r_rem0;
    logic [3*32-1:0]   r_quo0;
    logic [3*31-1:0]   r_low;
    logic [DSIDE_W-1:0] r_ds0;
    always_ff @(posedge i_clk) begin
        r_den <= {1'b0, w_r};
        r_ds0 <= {w_sd[SIDE_W-1 -: 3], w_sd[0]};
        for (int j = 0; j < 3; j++) begin
            r_rem0[49*j +: 49] <= 49'(n_dvd[j] >> 31);
            r_quo0[32*j +: 32] <= '0;
            r_low[31*j +: 31]  <= n_dvd[j][30:0];
        end
    end

    // the high 32 bits of the dividend are below r (m*2^15 < r since r >= m*2^16), so
    // r_rem0 starts as a valid remainder; the chain brings in the 31 low bits, one a cell,
    // plus one spare step that only doubles (quotient bit there is zero only if < r)
    logic [48:0]        d_den  [DIV_CELLS+1];
    logic [3*49-1:0]    d_rem  [DIV_CELLS+1];
    logic [3*32-1:0]    d_quo  [DIV_CELLS+1];
    logic [DSIDE_W+93-1:0] d_side [DIV_CELLS+1];
    logic [3*49-1:0]    d_feed [DIV_CELLS];
    assign d_den[0]  = r_den;
    assign d_rem[0]  = r_rem0;
    assign d_quo[0]  = r_quo0;
    assign d_side[0] = {r_ds0, r_low};
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        // the remainder goes to the cell as it is; the dividend bit is added after the cell
        always_comb begin
            for (int j = 0; j < 3; j++) begin
                if (g < 31) begin
                    d_feed[g][49*j +: 49] = d_rem[g][49*j +: 49];
                end else begin
                    d_feed[g][49*j +: 49] = d_rem[g][49*j +: 49];
                end
            end
        end
        logic [3*49-1:0] w_in;
        logic [3*49-1:0] w_out;
        logic [3*32-1:0] w_q;
        aarm_div_cell #(.SIDE_W(DSIDE_W + 93)) u_cell (
            .i_clk (i_clk),
            .i_den (d_den[g]), .i_rem (w_in), .i_quo (d_quo[g]), .i_side(d_side[g]),
            .o_den (d_den[g+1]), .o_rem (w_out), .o_quo (w_q), .o_side(d_side[g+1])
        );
        // cell shifts in a zero; the real bit is added after: (2R+b) - D sign matters, so
        // the bit is put in before the cell by using a half-shifted value is avoided;
        // instead the cell compares 2R against D and b fixes up exactly when 2R+b == D
        always_comb begin
            w_in = d_feed[g];
        end
        logic [2:0] w_b;
        always_comb begin
            for (int j = 0; j < 3; j++) begin
                w_b[j] = (g < 31) ? d_side[g][31*j + 30 - ((g < 31) ? g : 0)] : 1'b0;
            end
        end
        logic [2:0] r_b;
        always_ff @(posedge i_clk) begin
            r_b <= w_b;
        end
        always_comb begin
            for (int j = 0; j < 3; j++) begin
                // fixup: quotient bit 0 with 2R+b == D means bit should be 1, remainder 0
                if (!w_q[32*j] && r_b[j] && (w_out[49*j +: 49] + 49'd1 == d_den[g+1])) begin
                    d_rem[g+1][49*j +: 49] = '0;
                    d_quo[g+1][32*j +: 32] = w_q[32*j +: 32] | 32'd1;
                end else begin
                    d_rem[g+1][49*j +: 49] = w_out[49*j +: 49] + {48'd0, r_b[j]};
                    d_quo[g+1][32*j +: 32] = w_q[32*j +: 32];
                end
            end
        end
    end

    // normalized axis, saturated, signed q2.30
    logic signed [32:0] r_u [3];
    logic r_zero_n;
    logic [DSIDE_W+93-1:0] w_ds;
    assign w_ds = d_side[DIV_CELLS];
    always_ff @(posedge i_clk) begin
        r_zero_n <= w_ds[93];
        for (int j = 0; j < 3; j++) begin
            logic [31:0] v;
            v = d_quo[DIV_CELLS][32*j +: 32] >> 1;
            if (v > 32'd1073741824) v = 32'd1073741824;
            r_u[j] <= w_ds[94 + 3 - 1 - j] ? -$signed({1'b0, v}) : $signed({1'b0, v});
        end
    end

    // sine / cosine path
    logic [31:0] r_x, r_x2;
    logic [1:0]  r_qa, r_qb;
    logic [63:0] n_x2;
    logic [64:0] r_xp;
    always_comb begin
        n_x2 = r_xp[64:33] * r_xp[64:33] + 64'd536870912;
    end
    always_ff @(posedge i_clk) begin
        r_xp <= 65'({35'd0, r_p} * PI_Q32) + 65'h100000000;
        r_qa <= r_q0;
        r_x  <= r_xp[64:33];
        r_x2 <= n_x2[61:30];
        r_qb <= r_qa;
    end

    logic [31:0] p_x [POLY_CELLS+1];
    logic [31:0] p_x2[POLY_CELLS+1];
    logic [1:0]  p_q [POLY_CELLS+1];
    logic [30:0] p_bs[POLY_CELLS+1];
    logic [30:0] p_bc[POLY_CELLS+1];
    assign p_x[0] = r_x; assign p_x2[0] = r_x2; assign p_q[0] = r_qb;
    assign p_bs[0] = 31'h40000000; assign p_bc[0] = 31'h40000000;
    for (genvar g = 0; g < POLY_CELLS; g++) begin : g_poly
        aarm_poly_cell #(.K(POLY_CELLS - g)) u_cell (
            .i_clk(i_clk), .i_x(p_x[g]), .i_x2(p_x2[g]), .i_q(p_q[g]),
            .i_bs(p_bs[g]), .i_bc(p_bc[g]),
            .o_x(p_x[g+1]), .o_x2(p_x2[g+1]), .o_q(p_q[g+1]),
            .o_bs(p_bs[g+1]), .o_bc(p_bc[g+1])
        );
    end

    logic signed [32:0] r_s, r_c;
    logic [63:0] n_sp;
    logic signed [32:0] n_s, n_c;
    logic signed [32:0] n_s_fold, n_c_fold;
    always_comb begin
        n_sp = p_x[POLY_CELLS] * {1'b0, p_bs[POLY_CELLS]} + 64'd536870912;
        n_s  = $signed({1'b0, n_sp[61:30]});
        n_c  = $signed({2'b0, p_bc[POLY_CELLS]});
        // quadrant folding
        case (p_q[POLY_CELLS])
            2'd0: begin n_s_fold = n_s;  n_c_fold = n_c;  end
            2'd1: begin n_s_fold = n_c;  n_c_fold = -n_s; end
            2'd2: begin n_s_fold = -n_s; n_c_fold = -n_c; end
            default: begin n_s_fold = -n_c; n_c_fold = n_s; end
        endcase
    end
    always_ff @(posedge i_clk) begin
        r_s <= n_s_fold;
        r_c <= n_c_fold;
    end

    // delay sine/cosine to meet the normalized axis
    localparam int SC_DLY = NORM_LAT - SC_LAT - 1;
    logic signed [32:0] r_sd [SC_DLY];
    logic signed [32:0] r_cd [SC_DLY];
    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_s;
        r_cd[0] <= r_c;
        for (int k = 1; k < SC_DLY; k++) begin
            r_sd[k] <= r_sd[k-1];
            r_cd[k] <= r_cd[k-1];
        end
    end

    // products: stage A u_i*u_j, u*s, t
    logic signed [32:0] r_uu [6];
    logic signed [32:0] r_us [3];
    logic signed [32:0] r_t, r_ca;
    logic r_za;
    always_ff @(posedge i_clk) begin
        r_uu[0] <= mulq(r_u[0], r_u[0]);
        r_uu[1] <= mulq(r_u[0], r_u[1]);
        r_uu[2] <= mulq(r_u[0], r_u[2]);
        r_uu[3] <= mulq(r_u[1], r_u[1]);
        r_uu[4] <= mulq(r_u[1], r_u[2]);
        r_uu[5] <= mulq(r_u[2], r_u[2]);
        for (int j = 0; j < 3; j++) r_us[j] <= mulq(r_u[j], r_sd[SC_DLY-1]);
        r_t  <= ONE_Q30 - r_cd[SC_DLY-1];
        r_ca <= r_cd[SC_DLY-1];
        r_za <= r_zero_n;
    end

    // stage B: times t, combine, round; identity for a zero axis
    logic [OUT_W-1:0] r_m [9];
    logic r_zb;
    logic signed [32:0] w_p [6];
    logic signed [34:0] w_e [9];
    always_comb begin
        for (int j = 0; j < 6; j++) w_p[j] = mulq(r_uu[j], r_t);
        w_e[0] = 35'(r_ca) + 35'(w_p[0]);
        w_e[1] = 35'(w_p[1]) - 35'(r_us[2]);
        w_e[2] = 35'(w_p[2]) + 35'(r_us[1]);
        w_e[3] = 35'(w_p[1]) + 35'(r_us[2]);
        w_e[4] = 35'(r_ca) + 35'(w_p[3]);
        w_e[5] = 35'(w_p[4]) - 35'(r_us[0]);
        w_e[6] = 35'(w_p[2]) - 35'(r_us[1]);
        w_e[7] = 35'(w_p[4]) + 35'(r_us[0]);
        w_e[8] = 35'(r_ca) + 35'(w_p[5]);
    end
    always_ff @(posedge i_clk) begin
        r_zb <= r_za;
        for (int j = 0; j < 9; j++) begin
            if (r_za) begin
                r_m[j] <= (j % 4 == 0) ? 18'd65536 : 18'd0;
            end else begin
                r_m[j] <= to_q16(w_e[j]);
            end
        end
    end

    assign o_m00 = r_m[0]; assign o_m01 = r_m[1]; assign o_m02 = r_m[2];
    assign o_m10 = r_m[3]; assign o_m11 = r_m[4]; assign o_m12 = r_m[5];
    assign o_m20 = r_m[6]; assign o_m21 = r_m[7]; assign o_m22 = r_m[8];
    assign o_zero_axis = r_zb;
endmodule

/* rtl/aarm_sqrt_cell.sv */
// aarm_sqrt_cell.sv: one bit of the restoring square root with side data carried along
`timescale 1ns / 1ps
module aarm_sqrt_cell import aarm_pkg::*; #(
    parameter int STEP = 0,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic [95:0]       i_rad,
    input  logic [48:0]       i_rem,
    input  logic [47:0]       i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic [95:0]       o_rad,
    output logic [48:0]       o_rem,
    output logic [47:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int SH = 94 - 2 * STEP;
    logic [50:0] n_trial;
    logic [50:0] n_cur;
    always_comb begin
        n_cur   = {i_rem, i_rad[SH +: 2]};
        n_trial = n_cur - {1'b0, i_root, 2'b01};
    end
    always_ff @(posedge i_clk) begin
        o_rad  <= i_rad;
        o_side <= i_side;
        if (!n_trial[50]) begin
            o_rem  <= n_trial[48:0];
            o_root <= {i_root[46:0], 1'b1};
        end else begin
            o_rem  <= n_cur[48:0];
            o_root <= {i_root[46:0], 1'b0};
        end
    end
endmodule

/* rtl/aarm_div_cell.sv */
// aarm_div_cell.sv: one quotient bit for three dividends sharing a divisor
`timescale 1ns / 1ps
module aarm_div_cell import aarm_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic [48:0]       i_den,
    input  logic [3*49-1:0]   i_rem,
    input  logic [3*32-1:0]   i_quo,
    input  logic [SIDE_W-1:0] i_side,
    output logic [48:0]       o_den,
    output logic [3*49-1:0]   o_rem,
    output logic [3*32-1:0]   o_quo,
    output logic [SIDE_W-1:0] o_side
);
    logic [49:0] n_sh [3];
    logic [49:0] n_df [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sh[j] = {i_rem[49*j +: 49], 1'b0};
            n_df[j] = n_sh[j] - {1'b0, i_den};
        end
    end
    always_ff @(posedge i_clk) begin
        o_den  <= i_den;
        o_side <= i_side;
        for (int j = 0; j < 3; j++) begin
            if (!n_df[j][49]) begin
                o_rem[49*j +: 49] <= n_df[j][48:0];
                o_quo[32*j +: 32] <= {i_quo[32*j +: 31], 1'b1};
            end else begin
                o_rem[49*j +: 49] <= n_sh[j][48:0];
                o_quo[32*j +: 32] <= {i_quo[32*j +: 31], 1'b0};
            end
        end
    end
endmodule

/* rtl/aarm_poly_cell.sv */
// aarm_poly_cell.sv: one horner bracket for sine and cosine, three stages
`timescale 1ns / 1ps
module aarm_poly_cell import aarm_pkg::*; #(
    parameter int K = 7
) (
    input  logic        i_clk,
    input  logic [31:0] i_x,
    input  logic [31:0] i_x2,
    input  logic [1:0]  i_q,
    input  logic [30:0] i_bs,
    input  logic [30:0] i_bc,
    output logic [31:0] o_x,
    output logic [31:0] o_x2,
    output logic [1:0]  o_q,
    output logic [30:0] o_bs,
    output logic [30:0] o_bc
);
    localparam logic [7:0] DS = sin_div(3'(K));
    localparam logic [7:0] DC = cos_div(3'(K));
    // reciprocals times 2^40, rounded up; exact for any numerator below 2^32
    localparam logic [39:0] MS = 40'(((64'd1 << 40) + 64'(DS) - 64'd1) / 64'(DS));
    localparam logic [39:0] MC = 40'(((64'd1 << 40) + 64'(DC) - 64'd1) / 64'(DC));
    logic [31:0] r_x, r_x2, r_xb, r_x2b;
    logic [1:0]  r_q, r_qb;
    logic [31:0] r_ns, r_nc;
    logic [51:0] r_hs, r_hc;
    logic [31:0] r_ls, r_lc;
    logic [63:0] n_ps, n_pc;
    logic [51:0] n_hs, n_hc;
    logic [51:0] n_ls, n_lc;
    logic [52:0] n_qs, n_qc;
    always_comb begin
        // product stays below 2^62, so the rounded numerator fits 32 bits
        n_ps = i_x2 * {1'b0, i_bs} + 64'd536870912;
        n_pc = i_x2 * {1'b0, i_bc} + 64'd536870912;
        // reciprocal product split in two halves of the constant
        n_hs = {20'd0, r_ns} * {32'd0, MS[39:20]};
        n_hc = {20'd0, r_nc} * {32'd0, MC[39:20]};
        n_ls = {20'd0, r_ns} * {32'd0, MS[19:0]};
        n_lc = {20'd0, r_nc} * {32'd0, MC[19:0]};
        n_qs = ({1'b0, r_hs} + {21'd0, r_ls}) >> 20;
        n_qc = ({1'b0, r_hc} + {21'd0, r_lc}) >> 20;
    end
    always_ff @(posedge i_clk) begin
        r_x   <= i_x;
        r_x2  <= i_x2;
        r_q   <= i_q;
        r_ns  <= n_ps[61:30] + 32'(DS / 2);
        r_nc  <= n_pc[61:30] + 32'(DC / 2);
        r_xb  <= r_x;
        r_x2b <= r_x2;
        r_qb  <= r_q;
        r_hs  <= n_hs;
        r_hc  <= n_hc;
        r_ls  <= n_ls[51:20];
        r_lc  <= n_lc[51:20];
        o_x   <= r_xb;
        o_x2  <= r_x2b;
        o_q   <= r_qb;
        o_bs  <= (n_qs >= 53'd1073741824) ? 31'd0 : 31'(53'd1073741824 - n_qs);
        o_bc  <= (n_qc >= 53'd1073741824) ? 31'd0 : 31'(53'd1073741824 - n_qc);
    end
endmodule

/* rtl/aarm_checker.sv */
// aarm_checker.sv: port-level assertions bound to the top level
`timescale 1ns / 1ps
module aarm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic [17:0] o_m00,
    input logic [17:0] o_m01,
    input logic [17:0] o_m11,
    input logic [17:0] o_m22,
    input logic        o_zero_axis
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_zero_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_axis |-> o_m00 == 18'd65536 && o_m11 == 18'd65536 &&
        o_m22 == 18'd65536 && o_m01 == 18'd0)
        else $error("zero axis without identity");
    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_m00[17] == 1'b0 && o_m00 > 18'd65536))
        else $error("entry out of range");
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (.*);

/* bench/testbench.sv */
// testbench.sv: self-checking bench for the axis-angle to rotation matrix pipeline
`timescale 1ns / 1ps
module testbench import aarm_pkg::*; ();

    // one result item: nine q1.16 entries and the zero-axis flag
    typedef struct {
        logic [17:0] ent[9];
        logic        zero;
    } t_rot_matrix;

    localparam int PIPE_LAT  = NORM_LAT + 2;
    localparam int CYCLE_CAP = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [15:0] i_axis_x = '0;
    logic signed [15:0] i_axis_y = '0;
    logic signed [15:0] i_axis_z = '0;
    logic [15:0] i_turn_angle = '0;
    logic        o_valid;
    logic signed [OUT_W-1:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;
    logic        o_zero_axis;

    t_rot_matrix matrix_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          idle_pct = 0;

    axis_angle_rotation_matrix dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_axis_x, .i_axis_y, .i_axis_z, .i_turn_angle,
        .o_valid,
        .o_m00, .o_m01, .o_m02, .o_m10, .o_m11, .o_m12, .o_m20, .o_m21, .o_m22,
        .o_zero_axis
    );

    always #2 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem, root, b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // signed q30 product, magnitude rounded half up
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma, mb;
        longint p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = longint'((ma * mb + (64'd1 << 29)) >> 30);
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    // 1 - x2*b/d with rounding and a floor at zero
    function automatic longint unsigned horner_step(input longint unsigned x2,
                                                    input longint unsigned b,
                                                    input longint unsigned d);
        longint unsigned t;
        t = (x2 * b + (64'd1 << 29)) >> 30;
        t = (t + d / 2) / d;
        return (t >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - t;
    endfunction

    function automatic void angle_sincos(input logic [15:0] ang, output longint s_o,
                                         output longint c_o);
        longint unsigned ph, p, x, x2, bs, bc;
        longint s, c;
        logic [1:0] quad;
        ph = {48'd0, ang} << 16;
        quad = ph[31:30];
        p = ph & 64'h3FFF_FFFF;
        x = (p * 64'd13493037705 + (64'd1 << 32)) >> 33;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        bs = 64'd1 << 30;
        bc = 64'd1 << 30;
        for (int k = 7; k >= 1; k--) begin
            bs = horner_step(x2, bs, (2 * k) * (2 * k + 1));
            bc = horner_step(x2, bc, (2 * k - 1) * (2 * k));
        end
        s = longint'((x * bs + (64'd1 << 29)) >> 30);
        c = longint'(bc);
        case (quad)
            2'd0: begin s_o = s;  c_o = c;  end
            2'd1: begin s_o = c;  c_o = -s; end
            2'd2: begin s_o = -s; c_o = -c; end
            default: begin s_o = -c; c_o = s; end
        endcase
    endfunction

    function automatic longint unit_part(input longint a, input longint unsigned r);
        longint unsigned m, u;
        m = (a < 0) ? -a : a;
        u = ((m << 46) + r / 2) / r;
        if (u > (64'd1 << 30)) u = 64'd1 << 30;
        return (a < 0) ? -longint'(u) : longint'(u);
    endfunction

    function automatic logic [17:0] round_q16(input longint v);
        longint unsigned m;
        longint r;
        m = (v < 0) ? -v : v;
        m = (m + 8192) >> 14;
        if (m > 65536) m = 65536;
        r = (v < 0) ? -longint'(m) : longint'(m);
        return r[17:0];
    endfunction

    function automatic t_rot_matrix rodrigues_matrix(input logic signed [15:0] ax,
                                                     input logic signed [15:0] ay,
                                                     input logic signed [15:0] az,
                                                     input logic [15:0] ang);
        t_rot_matrix res;
        longint a[3], u[3], w[3];
        longint s, c, t;
        longint unsigned n2, r;
        longint mv[9];
        a[0] = ax;
        a[1] = ay;
        a[2] = az;
        n2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        if (n2 == 0) begin
            // identity regardless of angle
            for (int i = 0; i < 9; i++) res.ent[i] = (i % 4 == 0) ? 18'd65536 : 18'd0;
            res.zero = 1'b1;
            return res;
        end
        r = int_sqrt(n2 << 32);
        for (int i = 0; i < 3; i++) u[i] = unit_part(a[i], r);
        angle_sincos(ang, s, c);
        t = (64'sd1 <<< 30) - c;
        for (int i = 0; i < 3; i++) w[i] = q30_mul(u[i], s);
        mv[0] = c + q30_mul(q30_mul(u[0], u[0]), t);
        mv[1] = q30_mul(q30_mul(u[0], u[1]), t) - w[2];
        mv[2] = q30_mul(q30_mul(u[0], u[2]), t) + w[1];
        mv[3] = q30_mul(q30_mul(u[1], u[0]), t) + w[2];
        mv[4] = c + q30_mul(q30_mul(u[1], u[1]), t);
        mv[5] = q30_mul(q30_mul(u[1], u[2]), t) - w[0];
        mv[6] = q30_mul(q30_mul(u[2], u[0]), t) - w[1];
        mv[7] = q30_mul(q30_mul(u[2], u[1]), t) + w[0];
        mv[8] = c + q30_mul(q30_mul(u[2], u[2]), t);
        for (int i = 0; i < 9; i++) res.ent[i] = round_q16(mv[i]);
        res.zero = 1'b0;
        return res;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [17:0] got,
                                   input logic [17:0] want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what,
                 $signed(got), $signed(want), cycle_count);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // compare each result against the oldest predicted matrix
    always @(posedge i_clk) begin
        t_rot_matrix want;
        logic [17:0] got[9];
        if (i_rst_n && o_valid) begin
            got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            if (matrix_q.size() == 0) begin
                report_mismatch("unexpected result", got[0], 18'd0);
            end else begin
                want = matrix_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.ent[i])
                        report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
                                        got[i], want.ent[i]);
                if (o_zero_axis !== want.zero)
                    report_mismatch("zero_axis", {17'd0, o_zero_axis}, {17'd0, want.zero});
            end
        end
    end

    // ---------------- stimulus ----------------

    // send one item; random idle cycles ahead of it per idle_pct
    task automatic send_item(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [15:0] ang);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_axis_x <= ax;
        i_axis_y <= ay;
        i_axis_z <= az;
        i_turn_angle <= ang;
        do @(posedge i_clk); while (busy);
        matrix_q.push_back(rodrigues_matrix(ax, ay, az, ang));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (matrix_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [15:0] angs[5] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
        // zero axis, angle ignored
        send_item(16'd0, 16'd0, 16'd0, 16'd0);
        send_item(16'd0, 16'd0, 16'd0, 16'hFFFF);
        // one axis at each quadrant boundary and at the largest angle
        foreach (angs[i]) send_item(16'd1, 16'd0, 16'd0, angs[i]);
        send_item(16'd0, 16'h8000, 16'd0, 16'd8192);
        send_item(16'd0, 16'd0, 16'h7FFF, 16'd1);
        // extremes of the axis fields
        send_item(16'h8000, 16'h8000, 16'h8000, 16'd12345);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd40000);
        send_item(16'h7FFF, 16'h8000, 16'h0001, 16'd65535);
        send_item(16'hFFFF, 16'd1, 16'hFFFF, 16'd24576);
        send_item(16'h8000, 16'd0, 16'd0, 16'd32768);
        send_item(16'd1, 16'd1, 16'd1, 16'd21845);
        send_item(16'h7FFF, 16'd1, 16'd0, 16'd5000);
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd60000);
        drain_results();
    endtask

    task automatic send_random_item();
        logic [15:0] a[3];
        logic [15:0] ang;
        int kind;
        kind = $urandom_range(9);
        ang = $urandom_range(65535);
        for (int i = 0; i < 3; i++) begin
            case (kind)
                0: a[i] = 16'($signed($urandom_range(6)) - 3);   // tiny axes
                1: a[i] = (i == $urandom_range(2)) ? 16'($urandom) : 16'd0;
                2: a[i] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                default: a[i] = 16'($urandom);
            endcase
        end
        if ($urandom_range(49) == 0) a = '{16'd0, 16'd0, 16'd0};
        if ($urandom_range(19) == 0)
            ang = {2'($urandom_range(3)), 14'd0} | 16'($urandom_range(1));
        send_item(a[0], a[1], a[2], ang);
    endtask

    task automatic test_random_phase(input int pct, input int count);
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            // occasional runs with no gaps at all
            if (n % 100 == 50) idle_pct = 0;
            if (n % 100 == 75) idle_pct = pct;
            send_random_item();
        end
        idle_pct = 0;
    endtask

    // sender holds off until the pipeline is empty, then resumes
    task automatic test_hold_off();
        for (int n = 0; n < 20; n++) send_random_item();
        drain_results();
        for (int n = 0; n < 20; n++) send_random_item();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 330);
        test_random_phase(69, 330);
        test_hold_off();
        test_random_phase(0, 300);
        test_random_phase(34, 330);
        drain_results();
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
